// ===== hdl/watc_pkg.sv =====
// shared types and constants of the window average threshold crossing unit
package watc_pkg;

	localparam int TIME_BITS     = 32;
	localparam int POSITION_BITS = 32;
	localparam int DENSITY_BITS  = 16;
	localparam int LENGTH_BITS   = 7;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [DENSITY_BITS-1:0] THRESHOLD_RESET = DENSITY_BITS'(32768);
	localparam int LENGTH_RESET = 8;

	typedef enum logic {
		CFG_WINDOW_LENGTH     = 1'b0,
		CFG_DENSITY_THRESHOLD = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic        [TIME_BITS-1:0]     time_step;
		logic signed [POSITION_BITS-1:0] position;
		logic        [DENSITY_BITS-1:0]  density;
	} sample_t;

	typedef struct packed {
		logic        [TIME_BITS-1:0]     found_time_step;
		logic signed [POSITION_BITS-1:0] interface_position;
	} result_t;

endpackage

// ===== hdl/window_average_threshold_crossing_unit.sv =====
// top level of the window average threshold crossing unit
//
// sample channel: one request per cycle carries time step, position and
// density. a time step above the current one (or the first after reset)
// clears the window and re-arms the detector. once the window of
// window_length samples is full and its density sum falls below
// density_threshold * window_length, one result goes out on the result
// channel: the time step and the floored midpoint of the oldest and newest
// window positions. the rest of that time step produces nothing.
// cfg channel: always ready; index 0 sets window_length (0 acts as 1, values
// above WINDOW_MAX saturate) and clears the window, index 1 sets the threshold.
// write it only while no sample is in flight.
// a sample is captured in the input register, and its result is written to the
// result register when that sample is processed.
// throughput: one sample per cycle while the result channel does not stall,
// set by the running sum update and the one-read-one-write window memories.
// a stalled result channel holds the result register; the sample in the input
// register then waits and sample_ready drops until the result is taken.
// reset: window empty, no time step seen, length min(8, WINDOW_MAX),
// threshold 32768; the window memories are not cleared.
module window_average_threshold_crossing_unit #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  watc_pkg::sample_t    sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output watc_pkg::result_t    result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  watc_pkg::cfg_index_t cfg_index,
	input  logic [watc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	import watc_pkg::*;

	localparam int AW   = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
	localparam int LW   = $clog2(WINDOW_MAX + 1);
	localparam int SUMW = DENSITY_BITS + LW;
	localparam int LEN_INIT = WINDOW_MAX < LENGTH_RESET ? WINDOW_MAX : LENGTH_RESET;

	// configuration
	logic [LW-1:0]           len_q;
	logic [DENSITY_BITS-1:0] thr_q;
	logic [SUMW-1:0]         limit_q;
	logic [LENGTH_BITS-1:0]  len_raw;
	logic [LW-1:0]           len_new;

	// window state
	logic [AW-1:0]        wp_q;
	logic [LW-1:0]        fill_q;
	logic [SUMW-1:0]      sum_q;
	logic [TIME_BITS-1:0] cur_step_q;
	logic                 seen_q;
	logic                 found_q;

	// input register
	logic                     valid_s1;
	sample_t                  smp_s1;
	logic                     fwd_d_s1;
	logic                     fwd_p_s1;
	logic [DENSITY_BITS-1:0]  fwd_dv_s1;
	logic [POSITION_BITS-1:0] fwd_pv_s1;

	// memory ports
	logic [DENSITY_BITS-1:0]  ram_d;
	logic [POSITION_BITS-1:0] ram_p;
	logic [AW-1:0]            rd_evict;
	logic [AW-1:0]            rd_old;
	logic [AW-1:0]            e_wp;

	// processing
	logic                     acc;
	logic                     proc;
	logic                     new_step;
	logic [LW-1:0]            fill_b;
	logic [SUMW-1:0]          sum_b;
	logic [AW-1:0]            wp_b;
	logic                     found_b;
	logic [AW-1:0]            wp_cur;
	logic                     full_b;
	logic [DENSITY_BITS-1:0]  rd_d;
	logic [POSITION_BITS-1:0] rd_p;
	logic [DENSITY_BITS-1:0]  evict;
	logic [LW-1:0]            fill_n;
	logic [SUMW-1:0]          sum_n;
	logic [AW-1:0]            wp_n;
	logic                     wr_en;
	logic                     hit;
	logic [POSITION_BITS-1:0] oldest;
	logic [POSITION_BITS:0]   mid_sum;

	assign cfg_ready    = 1'b1;
	assign proc         = valid_s1 && (!result_valid || result_ready);
	assign sample_ready = !valid_s1 || proc;
	assign acc          = sample_valid && sample_ready;

	assign len_raw = cfg_data[LENGTH_BITS-1:0];
	always_comb begin
		priority if (len_raw == '0) begin
			len_new = LW'(1);
		end else if (int'(len_raw) > WINDOW_MAX) begin
			len_new = LW'(WINDOW_MAX);
		end else begin
			len_new = LW'(len_raw);
		end
	end

	always_comb begin
		new_step = !seen_q || (smp_s1.time_step > cur_step_q);
		fill_b   = new_step ? '0 : fill_q;
		sum_b    = new_step ? '0 : sum_q;
		wp_b     = new_step ? '0 : wp_q;
		found_b  = new_step ? 1'b0 : found_q;
		wp_cur   = (LW'(wp_b) >= len_q) ? '0 : wp_b;
		full_b   = fill_b >= len_q;
		rd_d     = fwd_d_s1 ? fwd_dv_s1 : ram_d;
		rd_p     = fwd_p_s1 ? fwd_pv_s1 : ram_p;
		evict    = full_b ? rd_d : '0;
		fill_n   = full_b ? fill_b : fill_b + LW'(1);
		sum_n    = sum_b - SUMW'(evict) + SUMW'(smp_s1.density);
		wp_n     = (LW'(wp_cur) == len_q - LW'(1)) ? '0 : wp_cur + AW'(1);
		wr_en    = proc && !found_b;
		hit      = wr_en && (fill_n >= len_q) && (sum_n < limit_q);
		oldest   = (len_q == LW'(1)) ? smp_s1.position : rd_p;
		mid_sum  = {oldest[POSITION_BITS-1], oldest}
			+ {smp_s1.position[POSITION_BITS-1], smp_s1.position};
	end

	// read addresses follow the state left by the sample processed this cycle
	always_comb begin
		priority if (proc && wr_en) begin
			e_wp = wp_n;
		end else if (proc) begin
			e_wp = wp_b;
		end else begin
			e_wp = wp_q;
		end
		rd_evict = e_wp;
		rd_old   = (LW'(e_wp) == len_q - LW'(1)) ? '0 : e_wp + AW'(1);
	end

	watc_ram #(
		.WIDTH(DENSITY_BITS),
		.DEPTH(WINDOW_MAX)
	) u_density_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wp_cur),
		.wdata(smp_s1.density),
		.re   (acc),
		.raddr(rd_evict),
		.rdata(ram_d)
	);

	watc_ram #(
		.WIDTH(POSITION_BITS),
		.DEPTH(WINDOW_MAX)
	) u_position_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wp_cur),
		.wdata(smp_s1.position),
		.re   (acc),
		.raddr(rd_old),
		.rdata(ram_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= LW'(LEN_INIT);
			thr_q        <= THRESHOLD_RESET;
			limit_q      <= SUMW'(THRESHOLD_RESET) * SUMW'(LEN_INIT);
			wp_q         <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			cur_step_q   <= '0;
			seen_q       <= 1'b0;
			found_q      <= 1'b0;
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_WINDOW_LENGTH: begin
						len_q   <= len_new;
						limit_q <= SUMW'(thr_q) * SUMW'(len_new);
						wp_q    <= '0;
						fill_q  <= '0;
						sum_q   <= '0;
					end
					CFG_DENSITY_THRESHOLD: begin
						thr_q   <= cfg_data[DENSITY_BITS-1:0];
						limit_q <= SUMW'(cfg_data[DENSITY_BITS-1:0]) * SUMW'(len_q);
					end
					default: begin
					end
				endcase
			end
			if (proc) begin
				seen_q <= 1'b1;
				if (new_step) begin
					cur_step_q <= smp_s1.time_step;
				end
				if (wr_en) begin
					wp_q    <= wp_n;
					fill_q  <= fill_n;
					sum_q   <= sum_n;
					found_q <= hit;
				end else begin
					wp_q    <= wp_b;
					fill_q  <= fill_b;
					sum_q   <= sum_b;
					found_q <= found_b;
				end
			end
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end
			if (proc) begin
				result_valid <= hit;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			smp_s1    <= sample;
			fwd_d_s1  <= wr_en && (wp_cur == rd_evict);
			fwd_p_s1  <= wr_en && (wp_cur == rd_old);
			fwd_dv_s1 <= smp_s1.density;
			fwd_pv_s1 <= smp_s1.position;
		end
		if (hit) begin
			result.found_time_step    <= smp_s1.time_step;
			result.interface_position <= mid_sum[POSITION_BITS:1];
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len_q)
		else $error("fill count above window length");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(wp_q) < len_q)
		else $error("write pointer outside window");

	a_hit_out: assert property (@(posedge clk) disable iff (!arst_n)
		hit |=> result_valid)
		else $error("crossing did not reach the result register");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result_valid && !result_ready) |-> !sample_ready)
		else $error("sample taken while input register is stalled");

	a_found_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && found_b) |-> !hit)
		else $error("second result in one time step");
`endif

endmodule

// ===== hdl/watc_ram.sv =====
// generic single write port memory with registered read
module watc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// testbench for the window average threshold crossing unit: directed and random samples checked against a predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import watc_pkg::*;

	localparam int WINDOW_MAX = 64;
	localparam int LONG_HOLD  = 400;
	localparam int PHASES     = 8;
	localparam int PHASE_ITEMS = 104;

	logic clk;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	sample_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_index_t cfg_index = CFG_WINDOW_LENGTH;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	window_average_threshold_crossing_unit #(
		.WINDOW_MAX(WINDOW_MAX)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sample_t queued_samples[$];
	result_t expected_crossings[$];
	result_t oldest_crossing;
	bit steady = 1'b0;
	int unsigned send_gap = 0;
	int unsigned take_gap = 0;
	int unsigned hold_left = 0;
	int unsigned take_draw;
	int unsigned results_taken = 0;
	int unsigned samples_taken = 0;
	int unsigned crossings_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned mismatches = 0;

	// predictor state
	logic [LENGTH_BITS-1:0] window_len = LENGTH_BITS'(LENGTH_RESET);
	logic [DENSITY_BITS-1:0] density_limit = THRESHOLD_RESET;
	logic [DENSITY_BITS-1:0] density_ring[WINDOW_MAX];
	logic [POSITION_BITS-1:0] position_ring[WINDOW_MAX];
	int unsigned ring_ptr = 0;
	int unsigned ring_fill = 0;
	int unsigned density_sum = 0;
	logic [TIME_BITS-1:0] open_step = '0;
	bit step_open = 1'b0;
	bit crossing_found = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned draw_wait();
		if (steady)
			return 0;
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
	endfunction

	function automatic int unsigned effective_length(logic [LENGTH_BITS-1:0] code);
		if (code == 0)
			return 1;
		if (code > WINDOW_MAX)
			return WINDOW_MAX;
		return code;
	endfunction

	function automatic void clear_ring();
		ring_ptr = 0;
		ring_fill = 0;
		density_sum = 0;
	endfunction

	function automatic void advance_window(sample_t s);
		int unsigned len;
		int unsigned ptr;
		logic [POSITION_BITS:0] pair_sum;
		result_t r;
		len = effective_length(window_len);
		if (!step_open || s.time_step > open_step) begin
			step_open = 1'b1;
			open_step = s.time_step;
			clear_ring();
			crossing_found = 1'b0;
		end
		if (crossing_found)
			return;
		ptr = (ring_ptr >= len) ? 0 : ring_ptr;
		if (ring_fill >= len)
			density_sum -= density_ring[ptr];
		else
			ring_fill++;
		density_ring[ptr] = s.density;
		position_ring[ptr] = s.position;
		density_sum += s.density;
		ptr = (ptr + 1 >= len) ? 0 : ptr + 1;
		ring_ptr = ptr;
		if (ring_fill >= len && density_sum < density_limit * len) begin
			crossing_found = 1'b1;
			// floored midpoint of oldest and newest, summed one bit wider
			pair_sum = {position_ring[ptr][POSITION_BITS-1], position_ring[ptr]}
				+ {s.position[POSITION_BITS-1], s.position};
			r.found_time_step = s.time_step;
			r.interface_position = pair_sum[POSITION_BITS:1];
			expected_crossings.push_back(r);
		end
	endfunction

	// sample driver
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || sample_ready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				sample_valid <= 1'b0;
			end else if (queued_samples.size() != 0) begin
				sample <= queued_samples.pop_front();
				sample_valid <= 1'b1;
				send_gap <= draw_wait();
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// result receiver, with long hold-offs to back up the pipeline
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else if (result_valid && result_ready) begin
			results_taken++;
			if (results_taken == 5 || results_taken == 30) begin
				hold_left <= LONG_HOLD;
				result_ready <= 1'b0;
			end else begin
				take_draw = draw_wait();
				take_gap <= take_draw;
				result_ready <= (take_draw == 0);
			end
		end else if (take_gap != 0) begin
			take_gap <= take_gap - 1;
			result_ready <= (take_gap == 1);
		end else begin
			result_ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_crossings.size() == 0) begin
					$error("unexpected result: found_time_step %0d interface_position %0d",
						result.found_time_step, result.interface_position);
					mismatches++;
				end else begin
					oldest_crossing = expected_crossings.pop_front();
					crossings_seen++;
					if (result.found_time_step !== oldest_crossing.found_time_step) begin
						$error("found_time_step expected %0d actual %0d",
							oldest_crossing.found_time_step, result.found_time_step);
						mismatches++;
					end
					if (result.interface_position !== oldest_crossing.interface_position) begin
						$error("interface_position expected %0d actual %0d",
							oldest_crossing.interface_position, result.interface_position);
						mismatches++;
					end
				end
			end
			if (sample_valid && sample_ready) begin
				samples_taken++;
				advance_window(sample);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WINDOW_LENGTH) begin
					window_len = cfg_data[LENGTH_BITS-1:0];
					clear_ring();
				end else begin
					density_limit = cfg_data[DENSITY_BITS-1:0];
				end
			end
		end
	end

	task automatic add_sample(logic [TIME_BITS-1:0] t, logic [POSITION_BITS-1:0] p,
		logic [DENSITY_BITS-1:0] d);
		sample_t s;
		s.time_step = t;
		s.position = p;
		s.density = d;
		queued_samples.push_back(s);
	endtask

	task automatic wait_idle();
		while (queued_samples.size() != 0 || sample_valid || expected_crossings.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic random_phase(int unsigned quota, logic [TIME_BITS-1:0] first_step,
		int unsigned len, logic [DENSITY_BITS-1:0] lim);
		logic [TIME_BITS-1:0] t;
		logic [POSITION_BITS-1:0] p;
		logic [DENSITY_BITS-1:0] d;
		int unsigned made;
		int unsigned count;
		int unsigned kind;
		int unsigned i;
		int v;
		t = first_step;
		made = 0;
		while (made < quota) begin
			count = (len > 8) ? $urandom_range(1, len + 6) : $urandom_range(1, 2 * len + 3);
			kind = $urandom_range(0, 3);
			for (i = 0; i < count && made < quota; i++) begin
				case (kind)
					0: d = DENSITY_BITS'($urandom);
					1, 2: d = (lim == 0) ? '0 : DENSITY_BITS'($urandom_range(0, lim - 1));
					default: begin
						v = int'(lim) + int'($urandom_range(0, 512)) - 256;
						if (v < 0)
							v = 0;
						if (v > 65535)
							v = 65535;
						d = DENSITY_BITS'(v);
					end
				endcase
				if ($urandom_range(0, 15) == 0)
					p = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
				else
					p = $urandom;
				// stray samples with a time step no later than the current one
				if ($urandom_range(0, 9) == 0)
					add_sample($urandom_range(0, t), $urandom, DENSITY_BITS'($urandom));
				else
					add_sample(t, p, d);
				made++;
			end
			t += $urandom_range(1, 3);
		end
	endtask

	initial begin
		int unsigned ph;
		int unsigned i;
		logic [LENGTH_BITS-1:0] len_code;
		logic [DENSITY_BITS-1:0] lim;
		logic [TIME_BITS-1:0] base;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: window of 8, crossing at first full window of low density
		add_sample(32'd0, 32'h8000_0000, 16'hffff);
		for (i = 0; i < 6; i++)
			add_sample(32'd0, $urandom, 16'h0000);
		add_sample(32'd0, 32'h7fff_ffff, 16'h0000);
		add_sample(32'd0, $urandom, 16'h0000);
		for (i = 0; i < 4; i++)
			add_sample(32'd7, $urandom, 16'hffff);
		for (i = 0; i < 4; i++)
			add_sample(32'd2, $urandom, 16'hffff);
		wait_idle();

		// zero length acts as one, full threshold
		write_register(CFG_WINDOW_LENGTH, 16'hff80);
		write_register(CFG_DENSITY_THRESHOLD, 16'hffff);
		add_sample(32'd8, 32'hffff_ffff, 16'hfffe);
		add_sample(32'd9, 32'd5, 16'hffff);
		add_sample(32'd9, 32'd3, 16'h0000);
		wait_idle();

		// oversize length saturates, zero threshold never crosses
		write_register(CFG_WINDOW_LENGTH, 16'h007f);
		write_register(CFG_DENSITY_THRESHOLD, 16'h0000);
		for (i = 0; i < 3; i++)
			add_sample(32'd10, $urandom, 16'h0000);

		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			steady = (ph == 1 || ph == 5);
			case (ph)
				0: len_code = 7'd4;
				1: len_code = 7'd0;
				2: len_code = 7'd127;
				3: len_code = 7'd2;
				5: len_code = 7'd3;
				7: len_code = 7'd64;
				default: len_code = LENGTH_BITS'($urandom_range(1, 12));
			endcase
			case (ph)
				1: lim = 16'hffff;
				3: lim = 16'h0000;
				default: lim = DENSITY_BITS'($urandom);
			endcase
			write_register(CFG_WINDOW_LENGTH, {9'($urandom), len_code});
			write_register(CFG_DENSITY_THRESHOLD, lim);
			if (ph == PHASES - 1)
				base = 32'hffff_f000;
			else
				base = (ph + 1) * 32'h2000_0000 + $urandom_range(0, 32'h00ff_ffff);
			random_phase(PHASE_ITEMS, base, effective_length(len_code), lim);
		end
		wait_idle();

		$display("%0d samples sent, %0d crossings checked, %0d register writes",
			samples_taken, crossings_seen, reg_writes);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/watc_pkg.sv
hdl/watc_ram.sv
hdl/window_average_threshold_crossing_unit.sv
bench/tb_top.sv
